[rtl/dfi_pkg.sv]
// Shared types, constants and RFC 1951 code tables for the fixed-Huffman inflater.
// No dependencies.
package dfi_pkg;

	localparam int WIN_AW   = 15;
	localparam int OBUF_MAX = 288;
	localparam int LANES    = 8;

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_STORED = 3'd2;
	localparam logic [2:0] ST_TYPE   = 3'd3;
	localparam logic [2:0] ST_DIST   = 3'd4;
	localparam logic [2:0] ST_TRUNC  = 3'd5;

	typedef struct packed {
		logic       v;
		logic [7:0] b;
	} emit_t;

	typedef struct packed {
		logic       v;
		logic [2:0] st;
	} done_t;

	function automatic logic [8:0] len_base(input logic [4:0] k);
		case (k)
			5'd0: return 9'd3;    5'd1: return 9'd4;    5'd2: return 9'd5;
			5'd3: return 9'd6;    5'd4: return 9'd7;    5'd5: return 9'd8;
			5'd6: return 9'd9;    5'd7: return 9'd10;   5'd8: return 9'd11;
			5'd9: return 9'd13;   5'd10: return 9'd15;  5'd11: return 9'd17;
			5'd12: return 9'd19;  5'd13: return 9'd23;  5'd14: return 9'd27;
			5'd15: return 9'd31;  5'd16: return 9'd35;  5'd17: return 9'd43;
			5'd18: return 9'd51;  5'd19: return 9'd59;  5'd20: return 9'd67;
			5'd21: return 9'd83;  5'd22: return 9'd99;  5'd23: return 9'd115;
			5'd24: return 9'd131; 5'd25: return 9'd163; 5'd26: return 9'd195;
			5'd27: return 9'd227; 5'd28: return 9'd258;
			default: return 9'd3;
		endcase
	endfunction

	function automatic logic [2:0] len_extra(input logic [4:0] k);
		if (k < 5'd8 || k == 5'd28) return 3'd0;
		return 3'(k[4:2] - 3'd1);
	endfunction

	function automatic logic [15:0] dist_base(input logic [4:0] c);
		case (c)
			5'd0: return 16'd1;      5'd1: return 16'd2;      5'd2: return 16'd3;
			5'd3: return 16'd4;      5'd4: return 16'd5;      5'd5: return 16'd7;
			5'd6: return 16'd9;      5'd7: return 16'd13;     5'd8: return 16'd17;
			5'd9: return 16'd25;     5'd10: return 16'd33;    5'd11: return 16'd49;
			5'd12: return 16'd65;    5'd13: return 16'd97;    5'd14: return 16'd129;
			5'd15: return 16'd193;   5'd16: return 16'd257;   5'd17: return 16'd385;
			5'd18: return 16'd513;   5'd19: return 16'd769;   5'd20: return 16'd1025;
			5'd21: return 16'd1537;  5'd22: return 16'd2049;  5'd23: return 16'd3073;
			5'd24: return 16'd4097;  5'd25: return 16'd6145;  5'd26: return 16'd8193;
			5'd27: return 16'd12289; 5'd28: return 16'd16385; 5'd29: return 16'd24577;
			default: return 16'd1;
		endcase
	endfunction

	function automatic logic [3:0] dist_extra(input logic [4:0] c);
		if (c < 5'd4) return 4'd0;
		return 4'(c[4:1] - 4'd1);
	endfunction

endpackage

[rtl/dfi_hist_ram.sv]
// History window: single-port-write, single-port-read synchronous RAM with registered read.
// Depends on dfi_pkg.
module dfi_hist_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [dfi_pkg::WIN_AW-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [dfi_pkg::WIN_AW-1:0] raddr,
	output logic [7:0]                 rdata
);
	import dfi_pkg::*;

	logic [7:0] mem [2**WIN_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/dfi_core.sv]
// Bit parser and match copier: one parse step per cycle while bits last, one copied byte per cycle.
// Depends on dfi_pkg and dfi_hist_ram.
module dfi_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output dfi_pkg::emit_t       emit,
	output dfi_pkg::done_t       done
);
	import dfi_pkg::*;

	typedef enum logic [3:0] {
		PH_HDR, PH_SHDR, PH_SDATA, PH_SYM, PH_LEN, PH_DIST, PH_COPY,
		PH_DONE, PH_ESTORED, PH_ETYPE, PH_EDIST, PH_ETRUNC
	} phase_t;

	phase_t              phase_q, n_phase;
	logic                busy_q, last_q, final_q, n_final;
	logic [31:0]         buf_q;
	logic [5:0]          cnt_q, n_drop, cnt_m3;
	logic [15:0]         left_q, n_left;
	logic [4:0]          k_q, n_k;
	logic [8:0]          mlen_q, n_mlen, rem_q;
	logic [15:0]         mdist_q, n_mdist, seen_q;
	logic [WIN_AW-1:0]   wpos_q, rdpos_q;
	logic                cp_v_s1, fwd_s1, stop, lit_v, terminal, issue;
	logic [7:0]          lit_b, lastb_q, rdata, emit_b;
	logic [39:0]         sh;
	logic [6:0]          c7;
	logic [7:0]          c8;
	logic [8:0]          c9;
	logic [4:0]          c5;
	logic [2:0]          le;
	logic [3:0]          de;
	logic [12:0]         dext;
	logic [4:0]          lext;
	logic [15:0]         dist_sum;
	done_t               done_q, done_n;

	always_comb begin
		for (int i = 0; i < 7; i++) c7[6-i] = buf_q[i];
		for (int i = 0; i < 8; i++) c8[7-i] = buf_q[i];
		for (int i = 0; i < 9; i++) c9[8-i] = buf_q[i];
		for (int i = 0; i < 5; i++) c5[4-i] = buf_q[i];
	end

	assign terminal = (phase_q == PH_DONE) || (phase_q == PH_ESTORED) ||
		(phase_q == PH_ETYPE) || (phase_q == PH_EDIST) || (phase_q == PH_ETRUNC);
	assign sh       = {32'd0, in_byte} << cnt_q;
	assign cnt_m3   = cnt_q - 6'd3;
	assign le       = len_extra(k_q);
	assign lext     = buf_q[4:0] & 5'((6'd1 << le) - 6'd1);
	assign de       = dist_extra(c5);
	assign dext     = buf_q[17:5] & 13'((14'd1 << de) - 14'd1);
	assign dist_sum = dist_base(c5) + {3'd0, dext};

	always_comb begin
		n_phase = phase_q;
		n_drop  = '0;
		stop    = 1'b0;
		lit_v   = 1'b0;
		lit_b   = buf_q[7:0];
		n_final = final_q;
		n_left  = left_q;
		n_k     = k_q;
		n_mlen  = mlen_q;
		n_mdist = mdist_q;
		case (phase_q)
			PH_HDR: begin
				if (cnt_q < 6'd3) begin
					stop = 1'b1;
				end else begin
					n_final = buf_q[0];
					n_drop  = 6'd3;
					case (buf_q[2:1])
						2'd0: begin
							n_drop  = 6'd3 + {3'd0, cnt_m3[2:0]};
							n_phase = PH_SHDR;
						end
						2'd1: n_phase = PH_SYM;
						default: n_phase = PH_ETYPE;
					endcase
				end
			end
			PH_SHDR: begin
				if (cnt_q < 6'd32) begin
					stop = 1'b1;
				end else begin
					n_drop = 6'd32;
					n_left = buf_q[15:0];
					if ((buf_q[15:0] ^ buf_q[31:16]) != 16'hFFFF) begin
						n_phase = PH_ESTORED;
					end else if (buf_q[15:0] == 16'd0) begin
						n_phase = final_q ? PH_DONE : PH_HDR;
					end else begin
						n_phase = PH_SDATA;
					end
				end
			end
			PH_SDATA: begin
				if (cnt_q < 6'd8) begin
					stop = 1'b1;
				end else begin
					lit_v  = 1'b1;
					n_drop = 6'd8;
					n_left = left_q - 16'd1;
					if (left_q == 16'd1) begin
						n_phase = final_q ? PH_DONE : PH_HDR;
					end
				end
			end
			PH_SYM: begin
				if (cnt_q < 6'd7) begin
					stop = 1'b1;
				end else if (c7 <= 7'd23) begin
					n_drop = 6'd7;
					if (c7 == 7'd0) begin
						n_phase = final_q ? PH_DONE : PH_HDR;
					end else begin
						n_k     = 5'(c7 - 7'd1);
						n_phase = PH_LEN;
					end
				end else if (cnt_q < 6'd8) begin
					stop = 1'b1;
				end else if (c8 <= 8'hBF) begin
					lit_v  = 1'b1;
					lit_b  = c8 - 8'h30;
					n_drop = 6'd8;
				end else if (c8 <= 8'hC7) begin
					n_drop = 6'd8;
					if (c8[2:0] >= 3'd6) begin
						n_phase = PH_ETYPE;
					end else begin
						n_k     = 5'd23 + {2'd0, c8[2:0]};
						n_phase = PH_LEN;
					end
				end else if (cnt_q < 6'd9) begin
					stop = 1'b1;
				end else begin
					lit_v  = 1'b1;
					lit_b  = c9[7:0];
					n_drop = 6'd9;
				end
			end
			PH_LEN: begin
				if (cnt_q < {3'd0, le}) begin
					stop = 1'b1;
				end else begin
					n_mlen  = len_base(k_q) + {4'd0, lext};
					n_drop  = {3'd0, le};
					n_phase = PH_DIST;
				end
			end
			PH_DIST: begin
				if (cnt_q < 6'd5) begin
					stop = 1'b1;
				end else if (c5 >= 5'd30) begin
					n_phase = PH_EDIST;
				end else if (cnt_q < 6'd5 + {2'd0, de}) begin
					stop = 1'b1;
				end else begin
					n_mdist = dist_sum;
					n_drop  = 6'd5 + {2'd0, de};
					n_phase = (dist_sum > seen_q) ? PH_EDIST : PH_COPY;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		done_n = '0;
		if (!start && busy_q) begin
			if (terminal) begin
				done_n.v = 1'b1;
				case (phase_q)
					PH_DONE:    done_n.st = ST_DONE;
					PH_ESTORED: done_n.st = ST_STORED;
					PH_ETYPE:   done_n.st = ST_TYPE;
					PH_EDIST:   done_n.st = ST_DIST;
					default:    done_n.st = ST_TRUNC;
				endcase
			end else if (phase_q != PH_COPY && stop) begin
				done_n.v  = 1'b1;
				done_n.st = last_q ? ST_TRUNC : ST_RUN;
			end
		end
	end

	assign issue  = busy_q && (phase_q == PH_COPY) && (rem_q != 9'd0);
	assign emit_b = cp_v_s1 ? (fwd_s1 ? lastb_q : rdata) : lit_b;
	assign emit.v = cp_v_s1 || (busy_q && !terminal && phase_q != PH_COPY && lit_v);
	assign emit.b = emit_b;
	assign done   = done_q;

	dfi_hist_ram u_hist (
		.clk   (clk),
		.we    (emit.v),
		.waddr (wpos_q),
		.wdata (emit_b),
		.raddr (rdpos_q - mdist_q[WIN_AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			busy_q  <= 1'b0;
			last_q  <= 1'b0;
			final_q <= 1'b0;
			buf_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			k_q     <= '0;
			mlen_q  <= '0;
			mdist_q <= '0;
			seen_q  <= '0;
			wpos_q  <= '0;
			rdpos_q <= '0;
			rem_q   <= '0;
			cp_v_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
			lastb_q <= '0;
			done_q  <= '0;
		end else begin
			done_q  <= done_n;
			cp_v_s1 <= issue;
			fwd_s1  <= issue && (mdist_q == 16'd1) && cp_v_s1;
			if (emit.v) begin
				lastb_q <= emit_b;
				wpos_q  <= wpos_q + 1'b1;
				if (seen_q < 16'(2**WIN_AW)) seen_q <= seen_q + 16'd1;
			end
			if (start) begin
				busy_q <= 1'b1;
				last_q <= in_last;
				if (!terminal) begin
					buf_q <= buf_q | sh[31:0];
					cnt_q <= cnt_q + 6'd8;
				end
			end else if (busy_q) begin
				if (terminal) begin
					busy_q <= 1'b0;
				end else if (phase_q == PH_COPY) begin
					if (issue) begin
						rdpos_q <= rdpos_q + 1'b1;
						rem_q   <= rem_q - 9'd1;
					end else if (!cp_v_s1) begin
						phase_q <= PH_SYM;
					end
				end else if (stop) begin
					busy_q <= 1'b0;
					if (last_q) begin
						phase_q <= PH_ETRUNC;
					end
				end else begin
					buf_q   <= buf_q >> n_drop;
					cnt_q   <= cnt_q - n_drop;
					phase_q <= n_phase;
					final_q <= n_final;
					left_q  <= n_left;
					k_q     <= n_k;
					mlen_q  <= n_mlen;
					mdist_q <= n_mdist;
					if (n_phase == PH_COPY) begin
						rem_q   <= n_mlen;
						rdpos_q <= lit_v ? wpos_q + 1'b1 : wpos_q;
					end
				end
			end
		end
	end

endmodule

[rtl/deflate_fixed_huffman_inflate.sv]
// Top level: DEFLATE inflater for stored and fixed-Huffman blocks, with output word buffer and drain.
// Depends on dfi_pkg and dfi_core.
//
//  channel | signals                                          | moves
//  in      | byte_valid, byte_ready, in_byte, in_last         | one compressed byte
//  out     | word_valid, word_ready, lane0..7, byte_count,    | up to 8 bytes
//          | run_last, status                                 |
//
// One parse step per cycle while bits are buffered; a match copy makes one byte per
// cycle through the history RAM. A byte's words are buffered until its parse ends,
// then each word is read, loaded and held until word_ready. Reset is asynchronous;
// the history RAM is not cleared. The next byte is taken once the last word is sent.
module deflate_fixed_huffman_inflate (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       word_valid,
	input  logic       word_ready,
	output logic [7:0] lane0,
	output logic [7:0] lane1,
	output logic [7:0] lane2,
	output logic [7:0] lane3,
	output logic [7:0] lane4,
	output logic [7:0] lane5,
	output logic [7:0] lane6,
	output logic [7:0] lane7,
	output logic [3:0] byte_count,
	output logic       run_last,
	output logic [2:0] status
);
	import dfi_pkg::*;

	typedef enum logic [2:0] {T_IDLE, T_RUN, T_RD, T_LD, T_SHOW} tstate_t;

	tstate_t           ts_q;
	emit_t             emit;
	done_t             done;
	logic [8:0]        olen_q;
	logic [7:0][7:0]   pack_q, pack_n, lane_q;
	logic [63:0]       obuf [OBUF_MAX/LANES];
	logic [63:0]       rd_word;
	logic [5:0]        idx_q, nres_q, nres_n;
	logic [2:0]        st_q, stat_q;
	logic [3:0]        cnt_q, cnt_n;
	logic              last_q, valid_q, wr_en, take, take_emit;
	logic [5:0]        wr_idx;
	logic [63:0]       wr_word;

	assign byte_ready = (ts_q == T_IDLE);
	assign take       = byte_valid && byte_ready;
	assign take_emit  = emit.v && (olen_q < 9'(OBUF_MAX));

	dfi_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (take),
		.in_byte (in_byte),
		.in_last (in_last),
		.emit    (emit),
		.done    (done)
	);

	always_comb begin
		pack_n = pack_q;
		pack_n[olen_q[2:0]] = emit.b;
		wr_en   = 1'b0;
		wr_idx  = olen_q[8:3];
		wr_word = pack_n;
		if (take_emit && olen_q[2:0] == 3'd7) begin
			wr_en = 1'b1;
		end else if (done.v && olen_q[2:0] != 3'd0) begin
			wr_en   = 1'b1;
			wr_word = pack_q;
		end
		nres_n = olen_q[8:3] + {5'd0, olen_q[2:0] != 3'd0};
		cnt_n  = (idx_q == nres_q - 6'd1 && olen_q[2:0] != 3'd0) ? {1'b0, olen_q[2:0]} : 4'd8;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			obuf[wr_idx] <= wr_word;
		end
		rd_word <= obuf[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q    <= T_IDLE;
			olen_q  <= '0;
			pack_q  <= '0;
			idx_q   <= '0;
			nres_q  <= '0;
			st_q    <= ST_RUN;
			stat_q  <= ST_RUN;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			valid_q <= 1'b0;
			lane_q  <= '0;
		end else begin
			if (take_emit) begin
				olen_q <= olen_q + 9'd1;
				pack_q <= (olen_q[2:0] == 3'd7) ? '0 : pack_n;
			end
			case (ts_q)
				T_IDLE: begin
					if (take) ts_q <= T_RUN;
				end
				T_RUN: begin
					if (done.v) begin
						st_q   <= done.st;
						nres_q <= nres_n;
						idx_q  <= '0;
						if (nres_n != 6'd0) begin
							ts_q <= T_RD;
						end else if (done.st != ST_RUN) begin
							lane_q  <= '0;
							cnt_q   <= '0;
							last_q  <= 1'b1;
							stat_q  <= done.st;
							valid_q <= 1'b1;
							ts_q    <= T_SHOW;
						end else begin
							ts_q <= T_IDLE;
						end
					end
				end
				T_RD: ts_q <= T_LD;
				T_LD: begin
					lane_q  <= rd_word;
					cnt_q   <= cnt_n;
					last_q  <= (idx_q == nres_q - 6'd1);
					stat_q  <= st_q;
					valid_q <= 1'b1;
					ts_q    <= T_SHOW;
				end
				T_SHOW: begin
					if (word_ready) begin
						valid_q <= 1'b0;
						if (last_q) begin
							olen_q <= '0;
							pack_q <= '0;
							ts_q   <= T_IDLE;
						end else begin
							idx_q <= idx_q + 6'd1;
							ts_q  <= T_RD;
						end
					end
				end
				default: ts_q <= T_IDLE;
			endcase
		end
	end

	assign word_valid = valid_q;
	assign lane0      = lane_q[0];
	assign lane1      = lane_q[1];
	assign lane2      = lane_q[2];
	assign lane3      = lane_q[3];
	assign lane4      = lane_q[4];
	assign lane5      = lane_q[5];
	assign lane6      = lane_q[6];
	assign lane7      = lane_q[7];
	assign byte_count = cnt_q;
	assign run_last   = last_q;
	assign status     = stat_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> byte_count <= 4'd8)
		else $error("byte_count above lane count");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !byte_ready)
		else $error("second byte taken during parse");

	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && status == ST_RUN |-> byte_count != 4'd0)
		else $error("empty word while running");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit.v |-> ts_q == T_RUN)
		else $error("byte made outside a parse");

endmodule
